FILE: hdl/arp_cache_with_request_retry_top_defines.svh
// Assertion macros used by the checker file.
`ifndef ARP_CACHE_WITH_REQUEST_RETRY_TOP_DEFINES_SVH
`define ARP_CACHE_WITH_REQUEST_RETRY_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ARPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/arpc_pkg.sv
// Shared constants, types and helpers of the ARP cache block.
package arpc_pkg;

    localparam int CACHE_ENTRIES = 64;
    localparam int PENDING_SLOTS = 16;
    localparam int TIME_BITS     = 32;

    localparam int CIDX_W   = $clog2(CACHE_ENTRIES);
    localparam int SIDX_W   = $clog2(PENDING_SLOTS);
    localparam int SCAN_LEN = (CACHE_ENTRIES > PENDING_SLOTS) ? CACHE_ENTRIES : PENDING_SLOTS;
    localparam int SCNT_W   = $clog2(SCAN_LEN + 1);

    localparam int ACT_W  = 2;
    localparam int KIND_W = 3;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int SLOT_W = 4;
    localparam int CRAM_W = IP_W + MAC_W + TIME_BITS;

    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 88;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 2;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUEUE  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUEUE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEND   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GIVEUP = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXS    = 2'd2;

    typedef struct packed {
        logic [15:0] timeout;
        logic [7:0]  retry;
        logic [2:0]  max_sends;
    } cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [SLOT_W-1:0] slot;
        logic              full;
        logic              last;
    } result_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [SIDX_W-1:0] s);
        to_slot = SLOT_W'(s);
    endfunction

    function automatic logic age_over(input logic [TIME_BITS-1:0] now,
                                      input logic [TIME_BITS-1:0] then,
                                      input logic [15:0] limit);
        logic [TIME_BITS-1:0] age;
        age = now - then;
        age_over = age > TIME_BITS'(limit);
    endfunction

endpackage

FILE: hdl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: hdl/arpc_front.sv
// Front end: accept input transfers, decode fields and queue them for the back end.
module arpc_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [arpc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [arpc_pkg::ACT_W-1:0]         s_tuser,
    output logic                               q_valid,
    output arpc_pkg::item_t                    q_item,
    input  logic                               q_pop
);

    arpc_pkg::item_t ent_reg [arpc_pkg::FIFO_DEPTH];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            push;
    arpc_pkg::item_t in_item;

    assign in_item.action = s_tuser;
    assign in_item.ip     = s_tdata[arpc_pkg::IP_W-1:0];
    assign in_item.mac    = s_tdata[arpc_pkg::IP_W +: arpc_pkg::MAC_W];

    assign s_tready = cnt_reg != 2'(arpc_pkg::FIFO_DEPTH);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                ent_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (!push && q_pop) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/arpc_back.sv
// Back end: sequence cache scans, pending table updates and the tick sweep.
module arpc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  arpc_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  arpc_pkg::item_t q_item,
    output logic            q_pop,
    output logic            out_valid,
    output arpc_pkg::result_t out_res,
    input  logic            out_ready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DONE  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_TAIL  = 3'd4;

    logic [2:0]                          state_reg;
    arpc_pkg::item_t                     item_reg;
    logic [arpc_pkg::TIME_BITS-1:0]      now_reg;
    logic [arpc_pkg::CACHE_ENTRIES-1:0]  cvalid_reg;
    logic [arpc_pkg::PENDING_SLOTS-1:0]  pvalid_reg;
    logic [arpc_pkg::IP_W-1:0]           pip_reg   [arpc_pkg::PENDING_SLOTS];
    logic [arpc_pkg::TIME_BITS-1:0]      psent_reg [arpc_pkg::PENDING_SLOTS];
    logic [2:0]                          pcnt_reg  [arpc_pkg::PENDING_SLOTS];

    logic [arpc_pkg::SCNT_W-1:0]         scan_reg;
    logic                                chk_vld_reg;
    logic [arpc_pkg::SCNT_W-1:0]         chk_idx_reg;
    logic                                hit_reg;
    logic [arpc_pkg::MAC_W-1:0]          mac_reg;
    logic                                phit_reg;
    logic [arpc_pkg::SIDX_W-1:0]         pslot_reg;
    logic                                cfree_reg;
    logic [arpc_pkg::CIDX_W-1:0]         cidx_reg;
    logic                                sfree_reg;
    logic [arpc_pkg::SIDX_W-1:0]         sidx_reg;
    logic [arpc_pkg::SIDX_W:0]           sweep_reg;
    logic                                held_vld_reg;
    arpc_pkg::result_t                   held_reg;
    logic                                out_vld_reg;
    arpc_pkg::result_t                   out_reg;

    logic [arpc_pkg::CRAM_W-1:0]         rdata;
    logic                                ram_we;
    logic [arpc_pkg::IP_W-1:0]           rd_ip;
    logic [arpc_pkg::MAC_W-1:0]          rd_mac;
    logic [arpc_pkg::TIME_BITS-1:0]      rd_time;
    logic [arpc_pkg::CIDX_W-1:0]         ci;
    logic [arpc_pkg::SIDX_W-1:0]         ps;
    logic                                c_in;
    logic                                p_in;
    logic                                out_free;
    logic [arpc_pkg::SIDX_W-1:0]         sw;
    logic                                sw_due;
    logic                                sw_give;
    arpc_pkg::result_t                   sw_res;
    arpc_pkg::result_t                   done_res;

    assign rd_ip   = rdata[arpc_pkg::CRAM_W-1 -: arpc_pkg::IP_W];
    assign rd_mac  = rdata[arpc_pkg::TIME_BITS +: arpc_pkg::MAC_W];
    assign rd_time = rdata[arpc_pkg::TIME_BITS-1:0];
    assign ci      = chk_idx_reg[arpc_pkg::CIDX_W-1:0];
    assign ps      = chk_idx_reg[arpc_pkg::SIDX_W-1:0];
    assign c_in    = chk_vld_reg && (chk_idx_reg < arpc_pkg::SCNT_W'(arpc_pkg::CACHE_ENTRIES));
    assign p_in    = chk_vld_reg && (chk_idx_reg < arpc_pkg::SCNT_W'(arpc_pkg::PENDING_SLOTS));
    assign out_free = !out_vld_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;

    assign ram_we = (state_reg == ST_DONE) && (item_reg.action == arpc_pkg::ACT_INSERT)
                    && cfree_reg && out_free;

    arpc_ram #(
        .WIDTH(arpc_pkg::CRAM_W),
        .DEPTH(arpc_pkg::CACHE_ENTRIES)
    ) u_cache_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(cidx_reg),
        .wdata({item_reg.ip, item_reg.mac, now_reg}),
        .raddr(scan_reg[arpc_pkg::CIDX_W-1:0]),
        .rdata(rdata)
    );

    assign sw      = sweep_reg[arpc_pkg::SIDX_W-1:0];
    assign sw_due  = pvalid_reg[sw] && ((pcnt_reg[sw] == 3'd0) ||
                     arpc_pkg::age_over(now_reg, psent_reg[sw], {8'd0, cfg.retry}));
    assign sw_give = pcnt_reg[sw] >= cfg.max_sends;

    always_comb begin
        sw_res      = '0;
        sw_res.kind = sw_give ? arpc_pkg::KIND_GIVEUP : arpc_pkg::KIND_SEND;
        sw_res.ip   = pip_reg[sw];
        sw_res.slot = arpc_pkg::to_slot(sw);
    end

    always_comb begin
        done_res    = '0;
        done_res.ip = item_reg.ip;
        done_res.last = 1'b1;
        case (item_reg.action)
            arpc_pkg::ACT_LOOKUP: begin
                done_res.kind = arpc_pkg::KIND_LOOKUP;
                done_res.hit  = hit_reg;
                done_res.mac  = hit_reg ? mac_reg : '0;
            end
            arpc_pkg::ACT_INSERT: begin
                done_res.kind = arpc_pkg::KIND_INSERT;
                done_res.hit  = phit_reg;
                done_res.slot = phit_reg ? arpc_pkg::to_slot(pslot_reg) : '0;
                done_res.full = !cfree_reg;
            end
            arpc_pkg::ACT_QUEUE: begin
                done_res.kind = arpc_pkg::KIND_QUEUE;
                done_res.hit  = phit_reg;
                if (phit_reg) begin
                    done_res.slot = arpc_pkg::to_slot(pslot_reg);
                end else if (sfree_reg) begin
                    done_res.slot = arpc_pkg::to_slot(sidx_reg);
                end else begin
                    done_res.full = 1'b1;
                end
            end
            default: begin
                done_res.kind = arpc_pkg::KIND_SEND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            cvalid_reg   <= '0;
            pvalid_reg   <= '0;
            chk_vld_reg  <= 1'b0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (out_vld_reg && out_ready) begin
                out_vld_reg <= 1'b0;
            end
            chk_vld_reg <= (state_reg == ST_SCAN) &&
                           (scan_reg < arpc_pkg::SCNT_W'(arpc_pkg::SCAN_LEN));
            chk_idx_reg <= scan_reg;

            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        scan_reg  <= '0;
                        hit_reg   <= 1'b0;
                        phit_reg  <= 1'b0;
                        cfree_reg <= 1'b0;
                        sfree_reg <= 1'b0;
                        if (q_item.action == arpc_pkg::ACT_TICK) begin
                            now_reg <= now_reg + arpc_pkg::TIME_BITS'(1);
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_reg < arpc_pkg::SCNT_W'(arpc_pkg::SCAN_LEN)) begin
                        scan_reg <= scan_reg + arpc_pkg::SCNT_W'(1);
                    end else if (!chk_vld_reg) begin
                        state_reg <= ST_DONE;
                    end
                    if (c_in) begin
                        case (item_reg.action)
                            arpc_pkg::ACT_LOOKUP: begin
                                if (cvalid_reg[ci] && rd_ip == item_reg.ip) begin
                                    hit_reg <= 1'b1;
                                    mac_reg <= rd_mac;
                                end
                            end
                            arpc_pkg::ACT_INSERT: begin
                                if (!cvalid_reg[ci] && !cfree_reg) begin
                                    cfree_reg <= 1'b1;
                                    cidx_reg  <= ci;
                                end
                            end
                            arpc_pkg::ACT_TICK: begin
                                if (cvalid_reg[ci] &&
                                    arpc_pkg::age_over(now_reg, rd_time, cfg.timeout)) begin
                                    cvalid_reg[ci] <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (p_in) begin
                        if (pvalid_reg[ps] && pip_reg[ps] == item_reg.ip && !phit_reg) begin
                            phit_reg  <= 1'b1;
                            pslot_reg <= ps;
                        end
                        if (!pvalid_reg[ps] && !sfree_reg) begin
                            sfree_reg <= 1'b1;
                            sidx_reg  <= ps;
                        end
                    end
                end
                ST_DONE: begin
                    if (item_reg.action == arpc_pkg::ACT_TICK) begin
                        sweep_reg <= '0;
                        state_reg <= ST_SWEEP;
                    end else if (out_free) begin
                        out_reg     <= done_res;
                        out_vld_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        if (item_reg.action == arpc_pkg::ACT_INSERT) begin
                            if (phit_reg) begin
                                pvalid_reg[pslot_reg] <= 1'b0;
                            end
                            if (cfree_reg) begin
                                cvalid_reg[cidx_reg] <= 1'b1;
                            end
                        end
                        if (item_reg.action == arpc_pkg::ACT_QUEUE && !phit_reg && sfree_reg) begin
                            pvalid_reg[sidx_reg] <= 1'b1;
                            pip_reg[sidx_reg]    <= item_reg.ip;
                            psent_reg[sidx_reg]  <= '0;
                            pcnt_reg[sidx_reg]   <= 3'd0;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (sweep_reg == (arpc_pkg::SIDX_W+1)'(arpc_pkg::PENDING_SLOTS)) begin
                        state_reg <= ST_TAIL;
                    end else if (!sw_due) begin
                        sweep_reg <= sweep_reg + (arpc_pkg::SIDX_W+1)'(1);
                    end else if (!held_vld_reg || out_free) begin
                        if (held_vld_reg) begin
                            out_reg     <= held_reg;
                            out_vld_reg <= 1'b1;
                        end
                        held_reg     <= sw_res;
                        held_vld_reg <= 1'b1;
                        if (sw_give) begin
                            pvalid_reg[sw] <= 1'b0;
                        end else begin
                            psent_reg[sw] <= now_reg;
                            pcnt_reg[sw]  <= pcnt_reg[sw] + 3'd1;
                        end
                        sweep_reg <= sweep_reg + (arpc_pkg::SIDX_W+1)'(1);
                    end
                end
                ST_TAIL: begin
                    if (!held_vld_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        out_reg      <= held_reg;
                        out_reg.last <= 1'b1;
                        out_vld_reg  <= 1'b1;
                        held_vld_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/arp_cache_with_request_retry_top.sv
// Top level of the ARP cache with pending-request retry.
//
// Input stream (s_*): one transfer per command. s_tuser carries the action
// (lookup, insert, queue request, one-second tick); s_tdata carries the IP
// and, for inserts, the MAC. Up to two commands wait in the front queue.
// Result stream (m_*): lookup, insert and queue give one transfer each with
// m_tlast set; a tick gives one send-ARP or give-up transfer per due
// pending slot, m_tlast on the final one, and nothing when none is due.
// Config port: cfg_wr_en writes cfg_wdata to the register cfg_index
// (0 entry timeout, 1 retry interval, 2 max sends); write only when idle.
// Scan: every command walks the cache RAM one entry per cycle; a tick
// then sweeps the pending slots in turn, and the sweep waits while a
// due result finds the output stalled. The cache RAM read port sets the
// scan rate.
// Reset clears all valid bits, the seconds counter and the config
// registers to their defaults; no clearing pass is needed.
// A stalled m_tready holds the result register and halts the back end at
// its next result, while the front queue keeps taking commands until it fills.
module arp_cache_with_request_retry_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [arpc_pkg::S_TDATA_W-1:0]      s_tdata,  // ip_addr[31:0], mac_addr[79:32]
    input  logic [arpc_pkg::ACT_W-1:0]          s_tuser,  // action[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [arpc_pkg::M_TDATA_W-1:0]      m_tdata,  // hit[0], mac_found[48:1],
                                                          // target_ip[80:49], request_slot[84:81],
                                                          // table_full[85], zero[87:86]
    output logic [arpc_pkg::KIND_W-1:0]         m_tuser,  // result_kind[2:0]
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    arpc_pkg::cfg_t    cfg_reg;
    logic              q_valid;
    arpc_pkg::item_t   q_item;
    logic              q_pop;
    arpc_pkg::result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout   <= 16'd15;
            cfg_reg.retry     <= 8'd1;
            cfg_reg.max_sends <= 3'd5;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                arpc_pkg::CFG_TIMEOUT: cfg_reg.timeout   <= cfg_wdata;
                arpc_pkg::CFG_RETRY:   cfg_reg.retry     <= cfg_wdata[7:0];
                arpc_pkg::CFG_MAXS:    cfg_reg.max_sends <= cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    arpc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    arpc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_res  (res),
        .out_ready(m_tready)
    );

    assign m_tdata = {2'b00, res.full, res.slot, res.ip, res.mac, res.hit};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

FILE: hdl/arpc_checker.sv
// Port-level checker for the ARP cache top level, with its bind.
`include "arp_cache_with_request_retry_top_defines.svh"

module arpc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [arpc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [arpc_pkg::KIND_W-1:0]    m_tuser,
    input logic                           m_tlast
);

    logic cmd_kind;
    logic sweep_kind;
    logic not_lookup;

    assign cmd_kind   = m_tuser inside {arpc_pkg::KIND_LOOKUP, arpc_pkg::KIND_INSERT,
                                        arpc_pkg::KIND_QUEUE};
    assign sweep_kind = m_tuser inside {arpc_pkg::KIND_SEND, arpc_pkg::KIND_GIVEUP};
    assign not_lookup = m_tuser != arpc_pkg::KIND_LOOKUP;

    `ARPC_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    `ARPC_ASSERT_IMP(a_mac_zero, aclk, aresetn, m_tvalid && not_lookup, m_tdata[48:1] == '0, "mac set outside lookup")

    `ARPC_ASSERT_IMP(a_single_last, aclk, aresetn, m_tvalid && cmd_kind, m_tlast, "command answer without last")

    `ARPC_ASSERT_IMP(a_sweep_flags, aclk, aresetn, m_tvalid && sweep_kind, !m_tdata[0] && !m_tdata[85], "sweep result with hit or full")

endmodule

bind arp_cache_with_request_retry_top arpc_checker u_arpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
